[sv/rsbn_pkg.sv]
// Package: shared constants, record and control types for the record sorter.
package rsbn_pkg;

	localparam int MAX_RECORDS = 64;
	localparam int NAME_BYTES  = 32;
	localparam int NAME_W      = 256;
	localparam int YEAR_W      = 14;
	localparam int MONTH_W     = 4;
	localparam int DAY_W       = 5;
	localparam int DATE_W      = YEAR_W + MONTH_W + DAY_W;
	localparam int TAG_W       = 8;
	localparam int RANK_W      = 6;
	localparam int OUT_LIMIT   = 64;
	localparam int IDX_W       = $clog2(MAX_RECORDS);
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
	localparam int IN_DATA_W   = 288;
	localparam int OUT_DATA_W  = 16;
	localparam int ADDR_W      = 3;

	localparam logic [ADDR_W-1:0] REG_SORT_MODE = 3'd0;
	localparam logic [YEAR_W-1:0] YEAR_SAT      = 14'd13422;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [NAME_W-1:0] name;
		logic [DATE_W-1:0] date;
	} rec_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_SORT,
		OP_SHIFT,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             parity;
		logic             mode;
		logic [IDX_W-1:0] load_idx;
	} ctrl_t;

endpackage

[sv/rsbn_intake.sv]
// Intake: cleans the name bytes after the terminator and forms the date ordering key.
module rsbn_intake import rsbn_pkg::*; (
	input  logic [TAG_W-1:0]   record_tag,
	input  logic [63:0]        name_word0,
	input  logic [63:0]        name_word1,
	input  logic [63:0]        name_word2,
	input  logic [63:0]        name_word3,
	input  logic [YEAR_W-1:0]  birth_year,
	input  logic [MONTH_W-1:0] birth_month,
	input  logic [DAY_W-1:0]   birth_day,
	output rec_t               rec
);

	logic [NAME_W-1:0] raw_name;
	logic [NAME_W-1:0] clean_name;
	logic              ended;

	assign raw_name = {name_word0, name_word1, name_word2, name_word3};

	always_comb begin
		clean_name = raw_name;
		ended      = 1'b0;
		for (int b = 0; b < NAME_W / 8; b++) begin
			if (b >= NAME_BYTES || raw_name[NAME_W-1-8*b -: 8] == 8'd0)
				ended = 1'b1;
			if (ended)
				clean_name[NAME_W-1-8*b -: 8] = 8'd0;
		end
	end

	// Month and day stay below 100, so the decimal key orders as the packed triple.
	// Every year from the saturation point up gives the same largest key.
	always_comb begin
		rec.tag  = record_tag;
		rec.name = clean_name;
		if (birth_year >= YEAR_SAT)
			rec.date = {YEAR_SAT, {MONTH_W{1'b0}}, {DAY_W{1'b0}}};
		else
			rec.date = {birth_year, birth_month, birth_day};
	end

endmodule

[sv/rsbn_cell.sv]
// Sorting cell: holds one record, compares it with its upper neighbour and swaps or shifts.
module rsbn_cell import rsbn_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  ctrl_t            ctrl,
	input  rec_t             load_rec,
	input  logic             upper_vld,
	input  rec_t             upper_rec,
	input  rec_t             lower_rec,
	input  logic             lower_gt,
	output logic             vld,
	output rec_t             rec,
	output logic             gt
);

	logic vld_q;
	rec_t rec_q;
	logic lo_act;
	logic key_gt;

	assign lo_act = (idx[0] == ctrl.parity);
	assign key_gt = ctrl.mode ? (rec_q.date > upper_rec.date) : (rec_q.name > upper_rec.name);
	assign gt     = vld_q && upper_vld && key_gt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_LOAD: begin
					if (idx == ctrl.load_idx)
						vld_q <= 1'b1;
				end
				OP_SHIFT: vld_q <= upper_vld;
				OP_CLEAR: vld_q <= 1'b0;
				default: vld_q <= vld_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				if (idx == ctrl.load_idx)
					rec_q <= load_rec;
			end
			OP_SORT: begin
				if (lo_act && gt)
					rec_q <= upper_rec;
				else if (!lo_act && lower_gt)
					rec_q <= lower_rec;
			end
			OP_SHIFT: rec_q <= upper_rec;
			default: rec_q <= rec_q;
		endcase
	end

	assign vld = vld_q;
	assign rec = rec_q;

endmodule

[sv/record_sort_by_name_or_date.sv]
// Top level: record sorter built as a chain of compare-and-swap cells.
// Records arrive on the s_axis channel, one request per cycle while s_tready is high.
// Each request is written straight into the next free cell; requests beyond
// MAX_RECORDS are dropped, but their tlast mark is still honoured.
// The request with tlast starts the sort: the chain runs MAX_RECORDS odd-even
// compare-and-swap phases, one per cycle, using the sort mode set over APB.
// Swaps only happen on a strict greater-than, so equal keys keep arrival order.
// The sorted tags then shift out of cell 0 on m_axis, one per cycle while the
// receiver takes them, with rank counting from zero and tlast on the final one.
// s_tready is low during the sort and drain; loading of the next run starts once
// the final result has entered the output register.
// A stalled receiver holds the output register and freezes the drain.
// Reset empties the chain, clears the record count and sets the sort mode to name order.
module record_sort_by_name_or_date import rsbn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// record_tag, name_word0, name_word1, name_word2, name_word3,
	// birth_year, birth_month, birth_day, then one zero bit
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// sorted_tag, rank, then two zero bits
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic                  m_tlast
);

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_SORT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t            state_q;
	logic              sort_mode_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  phase_q;
	logic [RANK_W-1:0] rank_q;
	logic              m_tvalid_q;
	logic [TAG_W-1:0]  out_tag_q;
	logic [RANK_W-1:0] out_rank_q;
	logic              out_last_q;

	ctrl_t             ctrl;
	rec_t              load_rec;
	logic              in_acc;
	logic              out_free;
	logic              issue;
	logic              issue_last;

	logic [MAX_RECORDS-1:0] cell_vld;
	logic [MAX_RECORDS-1:0] cell_gt;
	rec_t                   cell_rec [MAX_RECORDS];

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SORT_MODE) ? {31'd0, sort_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sort_mode_q <= 1'b0;
		else if (psel && penable && pwrite && pready && paddr == REG_SORT_MODE)
			sort_mode_q <= pwdata[0];
	end

	rsbn_intake u_intake (
		.record_tag  (s_tdata[7:0]),
		.name_word0  (s_tdata[71:8]),
		.name_word1  (s_tdata[135:72]),
		.name_word2  (s_tdata[199:136]),
		.name_word3  (s_tdata[263:200]),
		.birth_year  (s_tdata[277:264]),
		.birth_month (s_tdata[281:278]),
		.birth_day   (s_tdata[286:282]),
		.rec         (load_rec)
	);

	assign s_tready   = (state_q == ST_LOAD);
	assign in_acc     = s_tvalid && s_tready;
	assign out_free   = !m_tvalid_q || m_tready;
	assign issue      = (state_q == ST_DRAIN) && out_free && cell_vld[0];
	assign issue_last = !cell_vld[1] || (rank_q == RANK_W'(OUT_LIMIT - 1));

	always_comb begin
		ctrl.op       = OP_HOLD;
		ctrl.parity   = phase_q[0];
		ctrl.mode     = sort_mode_q;
		ctrl.load_idx = count_q[IDX_W-1:0];
		case (state_q)
			ST_LOAD: begin
				if (in_acc && count_q < CNT_W'(MAX_RECORDS))
					ctrl.op = OP_LOAD;
			end
			ST_SORT: ctrl.op = OP_SORT;
			ST_DRAIN: begin
				if (issue)
					ctrl.op = issue_last ? OP_CLEAR : OP_SHIFT;
			end
			default: ctrl.op = OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		logic upper_vld;
		rec_t upper_rec;
		rec_t lower_rec;
		logic lower_gt;

		if (i == MAX_RECORDS - 1) begin : g_top
			assign upper_vld = 1'b0;
			assign upper_rec = '0;
		end else begin : g_mid
			assign upper_vld = cell_vld[i+1];
			assign upper_rec = cell_rec[i+1];
		end

		if (i == 0) begin : g_bot
			assign lower_rec = '0;
			assign lower_gt  = 1'b0;
		end else begin : g_up
			assign lower_rec = cell_rec[i-1];
			assign lower_gt  = cell_gt[i-1];
		end

		rsbn_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (IDX_W'(i)),
			.ctrl      (ctrl),
			.load_rec  (load_rec),
			.upper_vld (upper_vld),
			.upper_rec (upper_rec),
			.lower_rec (lower_rec),
			.lower_gt  (lower_gt),
			.vld       (cell_vld[i]),
			.rec       (cell_rec[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			phase_q    <= '0;
			rank_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (issue)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (count_q < CNT_W'(MAX_RECORDS))
							count_q <= count_q + 1'b1;
						if (s_tlast) begin
							state_q <= ST_SORT;
							phase_q <= '0;
						end
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == IDX_W'(MAX_RECORDS - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (issue) begin
						rank_q <= rank_q + 1'b1;
						if (issue_last) begin
							state_q <= ST_LOAD;
							count_q <= '0;
							rank_q  <= '0;
						end
					end else if (!cell_vld[0]) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						rank_q  <= '0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			out_tag_q  <= cell_rec[0].tag;
			out_rank_q <= rank_q;
			out_last_q <= issue_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_rank_q, out_tag_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, cell_vld} + 1'b1))
	else $error("occupied cells are not a contiguous run from cell 0");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ($countones(cell_vld) == count_q))
	else $error("record count disagrees with occupied cells while loading");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |=> ($countones(cell_vld) == $past($countones(cell_vld))))
	else $error("sort phase changed the number of records");

	assert property (@(posedge clk) disable iff (!arst_n)
		(issue && issue_last) |=> (cell_vld == '0 && state_q == ST_LOAD))
	else $error("chain not empty after the final result");
`endif

endmodule

[verif/tb_record_sort_by_name_or_date.sv]
// Testbench for the record sorter: directed and random record sets, a scoreboard holding expected sorted tags.
module tb_record_sort_by_name_or_date;
	timeunit 1ns;
	timeprecision 1ps;
	import rsbn_pkg::*;

	localparam int          CYCLE_LIMIT  = 300000;
	localparam int          RANDOM_ITEMS = 215;
	localparam int          LONG_HOLD    = 400;
	localparam int unsigned DATE_SCALE   = 100;
	localparam int unsigned KEY_CEIL     = 32'h07FF_FFFF;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [NAME_W-1:0] name;
		logic [26:0]       key;
	} held_record_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [RANK_W-1:0] rank;
		logic              last;
	} sorted_out_t;

	class sort_scoreboard;
		logic         mode;
		held_record_t held[MAX_RECORDS];
		int           held_count;
		sorted_out_t  pending[$];
		int           errors;

		function new();
			mode = 1'b0;
			held_count = 0;
			errors = 0;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, what);
		endtask

		function bit orders_after(held_record_t a, held_record_t b);
			return mode ? (a.key > b.key) : (a.name > b.name);
		endfunction

		function void note_record(logic [IN_DATA_W-1:0] d, logic mark_last);
			held_record_t      r;
			held_record_t      line_up[MAX_RECORDS];
			held_record_t      swap_tmp;
			logic [NAME_W-1:0] nm;
			bit                ended;
			int unsigned       raw_key;
			int                j;
			if (held_count < MAX_RECORDS) begin
				r.tag = d[7:0];
				nm = {d[71:8], d[135:72], d[199:136], d[263:200]};
				ended = 1'b0;
				for (int b = 0; b < NAME_BYTES; b++) begin
					if (nm[NAME_W-1-8*b -: 8] == 8'h00)
						ended = 1'b1;
					if (ended)
						nm[NAME_W-1-8*b -: 8] = 8'h00;
				end
				r.name = nm;
				raw_key = (32'(d[277:264]) * DATE_SCALE + 32'(d[281:278])) * DATE_SCALE
					+ 32'(d[286:282]);
				r.key = (raw_key > KEY_CEIL) ? KEY_CEIL[26:0] : raw_key[26:0];
				held[held_count] = r;
				held_count++;
			end
			if (!mark_last)
				return;
			for (int i = 0; i < held_count; i++)
				line_up[i] = held[i];
			for (int i = 1; i < held_count; i++) begin
				j = i;
				while (j > 0 && orders_after(line_up[j-1], line_up[j])) begin
					swap_tmp = line_up[j-1];
					line_up[j-1] = line_up[j];
					line_up[j] = swap_tmp;
					j--;
				end
			end
			for (int i = 0; i < held_count; i++)
				pending.push_back('{tag: line_up[i].tag, rank: RANK_W'(i),
					last: (i == held_count - 1)});
			held_count = 0;
		endfunction

		task check_result(logic [TAG_W-1:0] tag, logic [RANK_W-1:0] rank, logic last);
			sorted_out_t want;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result tag %0d rank %0d", tag, rank));
				return;
			end
			want = pending.pop_front();
			if (tag !== want.tag)
				report_mismatch($sformatf("rank %0d: tag %0d, wanted %0d", want.rank, tag, want.tag));
			if (rank !== want.rank)
				report_mismatch($sformatf("rank %0d, wanted %0d", rank, want.rank));
			if (last !== want.last)
				report_mismatch($sformatf("rank %0d: last %b, wanted %b", want.rank, last, want.last));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	// record_tag, name_word0, name_word1, name_word2, name_word3,
	// birth_year, birth_month, birth_day, then one zero bit
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	// sorted_tag, rank, then two zero bits
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;

	sort_scoreboard sb;
	bit             tx_random;
	bit             rx_random;
	bit             hold_request;
	int             cycle_count;

	record_sort_by_name_or_date u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && s_tvalid && s_tready)
			sb.note_record(s_tdata, s_tlast);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid && m_tready)
			sb.check_result(m_tdata[7:0], m_tdata[13:8], m_tlast);
	end

	function automatic int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_record(logic [7:0] tag, logic [NAME_W-1:0] name,
			logic [13:0] year, logic [3:0] month, logic [4:0] day);
		return {1'b0, day, month, year, name[63:0], name[127:64], name[191:128], name[255:192], tag};
	endfunction

	function automatic logic [NAME_W-1:0] random_name();
		logic [NAME_W-1:0] nm;
		int                len;
		int                alpha;
		for (int i = 0; i < NAME_W / 32; i++)
			nm[32*i +: 32] = $urandom;
		if ($urandom_range(0, 9) < 6) begin
			len = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, NAME_BYTES);
			alpha = $urandom_range(0, 1) ? 2 : 26;
			for (int b = 0; b < NAME_BYTES; b++) begin
				if (b < len)
					nm[NAME_W-1-8*b -: 8] = 8'h41 + 8'($urandom_range(0, alpha - 1));
				else if (b == len || $urandom_range(0, 1))
					nm[NAME_W-1-8*b -: 8] = 8'h00;
			end
		end
		return nm;
	endfunction

	function automatic logic [IN_DATA_W-1:0] random_record();
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		int          pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			year = 14'($urandom_range(1990, 1992));
			month = 4'($urandom_range(1, 2));
			day = 5'($urandom_range(1, 3));
		end else if (pick < 8) begin
			year = 14'($urandom);
			month = 4'($urandom);
			day = 5'($urandom);
		end else begin
			year = 14'($urandom_range(13400, 16383));
			month = 4'($urandom);
			day = 5'($urandom);
		end
		return pack_record(8'($urandom), random_name(), year, month, day);
	endfunction

	task automatic write_sort_mode(input logic mode);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_SORT_MODE;
		pwdata <= {31'b0, mode};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.mode = mode;
	endtask

	task automatic send_record(input logic [IN_DATA_W-1:0] rec, input logic mark_last);
		int gap;
		gap = pick_gap(tx_random);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rec;
		s_tlast <= mark_last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_set(input int n);
		for (int i = 0; i < n; i++)
			send_record(random_record(), i == n - 1);
	endtask

	task automatic go_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (MAX_RECORDS + 8) @(posedge clk);
	endtask

	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = hold_request ? LONG_HOLD : pick_gap(rx_random);
			hold_request = 1'b0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int counted;
		int phase;
		int n;
		sb = new();
		cycle_count = 0;
		tx_random = 1'b0;
		rx_random = 1'b0;
		hold_request = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Name order: extreme names, bytes after the terminator, ties and last-byte differences.
		write_sort_mode(1'b0);
		send_record(pack_record(8'hFF, {32{8'hFF}}, 14'h3FFF, 4'hF, 5'h1F), 1'b0);
		send_record(pack_record(8'h00, '0, 14'd0, 4'd0, 5'd0), 1'b0);
		send_record(pack_record(8'h11, {8'h41, 8'h42, 8'h00, {29{8'h5A}}}, 14'd2000, 4'd1, 5'd1),
			1'b0);
		send_record(pack_record(8'h22, {8'h41, 8'h42, 240'h0}, 14'd1999, 4'd1, 5'd1), 1'b0);
		send_record(pack_record(8'h33, {8'h41, 8'h42, 8'h01, 232'h0}, 14'd1, 4'd2, 5'd3), 1'b0);
		send_record(pack_record(8'h44, {{31{8'h41}}, 8'h02}, 14'd5, 4'd5, 5'd5), 1'b0);
		send_record(pack_record(8'h55, {{31{8'h41}}, 8'h01}, 14'd6, 4'd6, 5'd6), 1'b1);
		send_record(pack_record(8'hA5, random_name(), 14'd1970, 4'd6, 5'd15), 1'b1);
		go_idle();

		// Date order: zero date, saturated keys, the edge just below saturation, equal keys.
		write_sort_mode(1'b1);
		send_record(pack_record(8'd1, random_name(), 14'd0, 4'd0, 5'd0), 1'b0);
		send_record(pack_record(8'd2, random_name(), 14'd16383, 4'd15, 5'd31), 1'b0);
		send_record(pack_record(8'd3, random_name(), 14'd13422, 4'd0, 5'd0), 1'b0);
		send_record(pack_record(8'd4, random_name(), 14'd13421, 4'd15, 5'd31), 1'b0);
		send_record(pack_record(8'd5, random_name(), 14'd1990, 4'd2, 5'd3), 1'b0);
		send_record(pack_record(8'd6, random_name(), 14'd1990, 4'd2, 5'd3), 1'b0);
		send_record(pack_record(8'd7, random_name(), 14'd5, 4'd15, 5'd31), 1'b0);
		send_record(pack_record(8'd8, random_name(), 14'd6, 4'd0, 5'd0), 1'b1);
		go_idle();

		counted = 0;
		phase = 0;
		while (counted < RANDOM_ITEMS) begin
			tx_random = (phase % 4 != 0);
			rx_random = (phase % 4 != 0);
			write_sort_mode(1'(phase % 2));
			case (phase)
				2: begin
					send_set(12);
					hold_request = 1'b1;
					send_set(9);
					counted += 21;
				end
				3: begin
					send_set(MAX_RECORDS);
					counted += MAX_RECORDS;
				end
				6: begin
					send_set(MAX_RECORDS + 3);
					counted += MAX_RECORDS;
				end
				default: begin
					repeat ($urandom_range(1, 4)) begin
						n = $urandom_range(0, 3) == 0 ? $urandom_range(13, 24) : $urandom_range(1, 8);
						send_set(n);
						counted += n;
					end
				end
			endcase
			go_idle();
			phase++;
		end

		repeat (2 * MAX_RECORDS) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
